[rtl/core/brd_pkg.sv]
package brd_pkg;

	typedef struct packed {
		logic [7:0] comp_byte;
		logic       last_byte;
	} brd_in_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] copies;
		logic       stream_end;
	} brd_out_t;

	// one finished pixel as handed from the parser to the output side
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       in_run;
		logic [7:0] run_count;
		logic       stream_end;
	} brd_pix_t;

	localparam logic [8:0] RUN_BASE = 9'd257;

endpackage

[rtl/core/brd_parse.sv]
module brd_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  brd_pkg::brd_in_t  in_data,
	output logic              push,
	output brd_pkg::brd_pix_t push_data,
	input  logic              q_full
);
	import brd_pkg::*;

	localparam logic [1:0] PH_CTRL  = 2'd0;
	localparam logic [1:0] PH_BLUE  = 2'd1;
	localparam logic [1:0] PH_GREEN = 2'd2;
	localparam logic [1:0] PH_RED   = 2'd3;

	logic [1:0] phase_q;
	logic       in_run_q;
	logic [7:0] literal_left_q;
	logic [7:0] run_count_q;
	logic [7:0] held_blue_q;
	logic [7:0] held_green_q;
	logic       accept;
	logic [7:0] chan;
	logic [7:0] lit_next;

	// only a red byte produces a pixel, so only it needs queue space
	assign in_ready = (phase_q != PH_RED) || !q_full;
	assign accept   = in_valid && in_ready;
	assign chan     = {in_data.comp_byte[6:0], 1'b0};
	assign lit_next = literal_left_q - 8'd1;
	assign push     = accept && (phase_q == PH_RED);

	always_comb begin
		push_data            = '0;
		push_data.blue       = held_blue_q;
		push_data.green      = held_green_q;
		push_data.red        = chan;
		push_data.in_run     = in_run_q;
		push_data.run_count  = run_count_q;
		push_data.stream_end = in_data.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_CTRL;
			in_run_q       <= 1'b0;
			literal_left_q <= '0;
			run_count_q    <= '0;
		end else if (accept) begin
			if (in_data.last_byte) begin
				phase_q        <= PH_CTRL;
				in_run_q       <= 1'b0;
				literal_left_q <= '0;
				run_count_q    <= '0;
			end else begin
				unique case (phase_q)
					PH_CTRL: begin
						if (in_data.comp_byte[7]) begin
							in_run_q       <= 1'b1;
							run_count_q    <= 8'(RUN_BASE - {1'b0, in_data.comp_byte});
							literal_left_q <= '0;
						end else begin
							in_run_q       <= 1'b0;
							literal_left_q <= in_data.comp_byte + 8'd1;
							run_count_q    <= '0;
						end
						phase_q <= PH_BLUE;
					end
					PH_BLUE:  phase_q <= PH_GREEN;
					PH_GREEN: phase_q <= PH_RED;
					PH_RED: begin
						if (in_run_q) begin
							phase_q <= PH_CTRL;
						end else begin
							literal_left_q <= lit_next;
							phase_q        <= (lit_next == 8'd0) ? PH_CTRL : PH_BLUE;
						end
					end
					default: phase_q <= PH_CTRL;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_BLUE) begin
			held_blue_q <= chan;
		end
		if (accept && phase_q == PH_GREEN) begin
			held_green_q <= chan;
		end
	end

endmodule

[rtl/core/brd_fifo.sv]
module brd_fifo #(
	parameter int Depth = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  brd_pkg::brd_pix_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output brd_pkg::brd_pix_t pop_data
);
	import brd_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	brd_pix_t        mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full     = (count_q == FullCnt);
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n) count_q <= FullCnt)
		else $error("queue count out of range");
	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CntW'(1)))
		else $error("queue count missed a write");

endmodule

[rtl/core/brd_out.sv]
module brd_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  brd_pkg::brd_pix_t q_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output brd_pkg::brd_out_t out_data
);
	import brd_pkg::*;

	logic     valid_q;
	brd_out_t data_q;
	brd_out_t next_data;

	// refill the output register when it is empty or being taken this cycle
	assign pop = !q_empty && (!valid_q || out_ready);

	always_comb begin
		next_data            = '0;
		next_data.blue       = q_data.blue;
		next_data.green      = q_data.green;
		next_data.red        = q_data.red;
		next_data.copies     = q_data.in_run ? q_data.run_count : 8'd1;
		next_data.stream_end = q_data.stream_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= next_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

[rtl/core/byte_run_rgb_decoder.sv]
// ByteRun (PackBits-style) decoder for a stream of RGB triples.
// Input channel (in_valid/in_ready/in_data): one compressed byte per
// transaction, with last_byte marking the end of a stream. A control byte
// with its top bit set starts a run of one pixel repeated 2 to 129 times;
// otherwise it starts 1 to 128 literal pixels. Each pixel is three bytes,
// blue, green, red, each shifted left one bit on output.
// Output channel (out_valid/out_ready/out_data): one transaction per pixel,
// with copies = 1 for literals or the run length; expand downstream.
// Throughput: one byte per cycle, except that a red byte waits while the
// queue is full. The edge that takes the red byte writes the pixel into a
// small queue; it moves on into the output register when that register is
// empty or its pixel is being taken, and out_valid is then high.
// Reset (arst_n low) returns the parser to the control-byte phase and
// empties the queue and the output register. A stream that ends mid-token
// emits nothing for the partial pixel.
// When the receiver stalls, the output register holds and the queue
// (QueueDepth pixels) absorbs parsed pixels; in_ready drops only on a red
// byte while the queue is full.
module byte_run_rgb_decoder #(
	parameter int QueueDepth = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  brd_pkg::brd_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output brd_pkg::brd_out_t out_data
);
	import brd_pkg::*;

	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_empty;
	brd_pix_t push_data;
	brd_pix_t pop_data;

	brd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	brd_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.pop_data  (pop_data)
	);

	brd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
	import brd_pkg::*;

	typedef enum logic [1:0] {PH_CTRL, PH_BLUE, PH_GREEN, PH_RED} phase_e;
	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	brd_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	brd_out_t out_data;

	byte_run_rgb_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// parser state mirrored from the block
	phase_e     phase;
	logic       run_mode;
	logic [7:0] lit_left;
	logic [7:0] run_len;
	logic [7:0] held_b;
	logic [7:0] held_g;

	brd_out_t   pixels_due[$];
	int         mismatches;
	int         bytes_sent;
	int         burst_left;
	bit         gaps_on;
	rx_mode_e   rx_mode;
	logic [15:0] rx_pattern;
	int         hold_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic report(input string what);
		mismatches++;
		$display("ERROR at %0t: %s", $time, what);
	endtask

	function automatic void clear_parser();
		phase    = PH_CTRL;
		run_mode = 1'b0;
		lit_left = '0;
		run_len  = '0;
		held_b   = '0;
		held_g   = '0;
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic last);
		logic [7:0] chan;
		brd_out_t   pix;
		chan = {b[6:0], 1'b0};
		case (phase)
			PH_CTRL: begin
				if (b[7]) begin
					run_mode = 1'b1;
					run_len  = 8'd1 - b;
					lit_left = '0;
				end else begin
					run_mode = 1'b0;
					lit_left = b + 8'd1;
					run_len  = '0;
				end
				phase = PH_BLUE;
			end
			PH_BLUE: begin
				held_b = chan;
				phase  = PH_GREEN;
			end
			PH_GREEN: begin
				held_g = chan;
				phase  = PH_RED;
			end
			default: begin
				pix.blue       = held_b;
				pix.green      = held_g;
				pix.red        = chan;
				pix.copies     = run_mode ? run_len : 8'd1;
				pix.stream_end = last;
				pixels_due     = {pixels_due, pix};
				if (run_mode) begin
					phase = PH_CTRL;
				end else begin
					lit_left = lit_left - 8'd1;
					phase    = (lit_left == 0) ? PH_CTRL : PH_BLUE;
				end
			end
		endcase
		if (last)
			clear_parser();
	endfunction

	task automatic check_pixel(input brd_out_t got);
		brd_out_t want;
		if (pixels_due.size() == 0) begin
			report($sformatf("unexpected pixel %h", got));
		end else begin
			want = pixels_due.pop_front();
			if (got.blue != want.blue)
				report($sformatf("blue %h, want %h", got.blue, want.blue));
			if (got.green != want.green)
				report($sformatf("green %h, want %h", got.green, want.green));
			if (got.red != want.red)
				report($sformatf("red %h, want %h", got.red, want.red));
			if (got.copies != want.copies)
				report($sformatf("copies %0d, want %0d", got.copies, want.copies));
			if (got.stream_end != want.stream_end)
				report($sformatf("stream_end %b, want %b", got.stream_end, want.stream_end));
		end
	endtask

	// called at a rising edge; returns at the edge where the byte was taken
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				in_data  <= brd_in_t'($urandom);
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		in_data  <= brd_in_t'({b, last});
		do @(posedge clk); while (!in_ready);
		decode_byte(b, last);
		bytes_sent++;
	endtask

	task automatic pick_receiver();
		rx_mode = rx_mode_e'($urandom_range(0, 2));
		rx_pattern = 16'($urandom) | 16'h0001;
	endtask

	// one stream of tokens; most end on their last byte, some are cut, some run on
	task automatic send_stream();
		logic [7:0] seq[$];
		logic [7:0] ctrl;
		int         ntok, npix, r, ending, len;
		ntok = $urandom_range(1, 4);
		for (int t = 0; t < ntok; t++) begin
			r = $urandom_range(0, 59);
			if (r < 22) begin
				ctrl = 8'($urandom_range(128, 255));
				npix = 1;
			end else if (r < 57) begin
				ctrl = 8'($urandom_range(0, 3));
				npix = ctrl + 1;
			end else if (r == 57) begin
				ctrl = 8'($urandom_range(4, 127));
				npix = ctrl + 1;
			end else begin
				ctrl = (r == 58) ? 8'd127 : 8'd128;
				npix = (r == 58) ? 128 : 1;
			end
			seq = {seq, ctrl};
			for (int p = 0; p < 3 * npix; p++)
				seq = {seq, 8'($urandom)};
		end
		ending = $urandom_range(0, 9);
		len = seq.size();
		if (ending == 7 || ending == 8)
			len = $urandom_range(1, seq.size());
		for (int k = 0; k < len; k++)
			send_byte(seq[k], (ending != 9) && (k == len - 1));
	endtask

	task automatic test_directed();
		gaps_on = 1'b1;
		rx_mode = RX_RANDOM;
		// single literal pixel with channel extremes
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		// longest run
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h01, 1'b0);
		// shortest run, closed by the last mark on red
		send_byte(8'hFF, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h2A, 1'b1);
		// last mark on a control byte
		send_byte(8'h05, 1'b1);
		// token cut short on green
		send_byte(8'h01, 1'b0);
		send_byte(8'h11, 1'b0);
		send_byte(8'h22, 1'b1);
		// two literals, then a run with no last mark in between
		send_byte(8'h01, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h3C, 1'b0);
		send_byte(8'h99, 1'b0);
		send_byte(8'h66, 1'b0);
		send_byte(8'hE7, 1'b0);
		send_byte(8'h18, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h03, 1'b1);
	endtask

	task automatic test_backpressure();
		gaps_on = 1'b0;
		rx_mode = RX_ALWAYS;
		hold_cycles = 300;
		send_byte(8'h0F, 1'b0);
		for (int p = 0; p < 48; p++)
			send_byte(8'($urandom), 1'b0);
		send_byte(8'h81, 1'b0);
		send_byte(8'($urandom), 1'b0);
		send_byte(8'($urandom), 1'b0);
		send_byte(8'($urandom), 1'b1);
	endtask

	task automatic test_random_streams(input int target);
		int stop_at;
		stop_at = bytes_sent + target;
		while (bytes_sent < stop_at) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			pick_receiver();
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom), $urandom_range(0, 5) == 0);
			end else begin
				send_stream();
			end
		end
	endtask

	task automatic test_streaming();
		gaps_on = 1'b0;
		rx_mode = RX_ALWAYS;
		repeat (8) send_stream();
	endtask

	task automatic drain_and_finish();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		rx_mode = RX_ALWAYS;
		while (pixels_due.size() > 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (pixels_due.size() > 0)
			report($sformatf("%0d pixels never arrived", pixels_due.size()));
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	endtask

	// receiver: check each transaction, then choose next ready
	initial begin : receiver
		logic nxt;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				check_pixel(out_data);
			if (hold_cycles > 0) begin
				nxt = 1'b0;
				hold_cycles--;
			end else begin
				case (rx_mode)
					RX_ALWAYS: nxt = 1'b1;
					RX_RANDOM: nxt = ($urandom_range(0, 3) != 0);
					default: begin
						nxt = rx_pattern[0];
						rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
					end
				endcase
			end
			out_ready <= nxt;
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_ready   = 1'b0;
		mismatches  = 0;
		bytes_sent  = 0;
		burst_left  = 0;
		gaps_on     = 1'b1;
		rx_mode     = RX_ALWAYS;
		rx_pattern  = 16'hA5B3;
		hold_cycles = 0;
		clear_parser();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random_streams(1400);
		test_streaming();
		drain_and_finish();
	end

endmodule

[byte_run_rgb_decoder.f]
rtl/core/brd_pkg.sv
rtl/core/brd_parse.sv
rtl/core/brd_fifo.sv
rtl/core/brd_out.sv
rtl/core/byte_run_rgb_decoder.sv
sim/tb.sv
